// ----- sv/trk_pkg.sv -----
package trk_pkg;

    localparam int HIST_DEPTH = 5;
    localparam int COUNT_W    = 3;
    localparam int OUT_W      = 14;
    localparam int OUT_MIN    = -8192;
    localparam int OUT_MAX    = 8191;

    // triangular divisors for three, four and five held centres
    localparam int TRI_3 = 3;
    localparam int TRI_4 = 6;
    localparam int TRI_5 = 10;

    // odd factors left after the power-of-two part of 2*divisor is shifted out
    localparam int FACT_3 = 3;
    localparam int FACT_5 = 5;

    typedef enum logic [1:0] {
        DIV_NONE = 2'b00,
        DIV_BY3  = 2'b01,
        DIV_BY5  = 2'b10
    } t_div_sel;

    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } t_pipe_en;

endpackage

// ----- sv/trk_center.sv -----
module trk_center
    import trk_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic [11:0]           i_edge,
    input  logic [12:0]           i_size,
    output logic [COORD_BITS-1:0] o_center
);

    localparam int CW = (COORD_BITS > 13) ? COORD_BITS : 13;
    localparam logic [CW-1:0] CMAX = CW'((2 ** COORD_BITS) - 1);

    logic [12:0]   sum;
    logic [CW-1:0] sum_ext;
    logic [CW-1:0] sat;

    assign sum     = {1'b0, i_edge} + {1'b0, i_size[12:1]};
    assign sum_ext = CW'(sum);
    // clip to the coordinate maximum
    assign sat      = (sum_ext > CMAX) ? CMAX : sum_ext;
    assign o_center = sat[COORD_BITS-1:0];

endmodule

// ----- sv/trk_history.sv -----
module trk_history
    import trk_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic                  i_new_track,
    input  logic [COORD_BITS-1:0] i_cx,
    input  logic [COORD_BITS-1:0] i_cy,
    output logic [COORD_BITS-1:0] o_hx [HIST_DEPTH],
    output logic [COORD_BITS-1:0] o_hy [HIST_DEPTH],
    output logic [COUNT_W-1:0]    o_count
);

    localparam logic [COUNT_W-1:0] FULL = COUNT_W'(HIST_DEPTH);

    logic [COORD_BITS-1:0] r_hx [HIST_DEPTH];
    logic [COORD_BITS-1:0] r_hy [HIST_DEPTH];
    logic [COORD_BITS-1:0] n_hx [HIST_DEPTH];
    logic [COORD_BITS-1:0] n_hy [HIST_DEPTH];
    logic [COUNT_W-1:0]    r_count;
    logic [COUNT_W-1:0]    n_count;
    logic [COUNT_W-1:0]    base;

    always_comb begin
        base    = i_new_track ? '0 : r_count;
        n_hx    = r_hx;
        n_hy    = r_hy;
        n_count = r_count;
        if (base == FULL) begin
            // drop the oldest entry
            for (int i = 1; i < HIST_DEPTH; i++) begin
                n_hx[i-1] = r_hx[i];
                n_hy[i-1] = r_hy[i];
            end
            n_hx[HIST_DEPTH-1] = i_cx;
            n_hy[HIST_DEPTH-1] = i_cy;
            n_count            = FULL;
        end else begin
            for (int i = 0; i < HIST_DEPTH; i++) begin
                if (base == COUNT_W'(i)) begin
                    n_hx[i] = i_cx;
                    n_hy[i] = i_cy;
                end
            end
            n_count = base + COUNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_push) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_hx <= n_hx;
            r_hy <= n_hy;
        end
    end

    assign o_hx    = r_hx;
    assign o_hy    = r_hy;
    assign o_count = r_count;

endmodule

// ----- sv/trk_lane.sv -----
module trk_lane
    import trk_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic                  i_clk,
    input  t_pipe_en              i_en,
    input  logic [COORD_BITS-1:0] i_hist [HIST_DEPTH],
    input  logic [COUNT_W-1:0]    i_count,
    output logic [OUT_W-1:0]      o_pred
);

    localparam int SW = COORD_BITS + 5;   // signed weighted sum
    localparam int AW = COORD_BITS + 4;   // magnitude of the sum
    localparam int MW = COORD_BITS + 5;   // 2*|sum| + divisor
    localparam int VW = COORD_BITS + 4;   // value after the power-of-two shift
    localparam int K  = VW;
    localparam int RW = VW + 2;
    localparam logic [K-1:0] R3 = K'((2 ** K) / FACT_3);
    localparam logic [K-1:0] R5 = K'((2 ** K) / FACT_5);
    localparam logic signed [RW-1:0] SAT_MAX = RW'(OUT_MAX);
    localparam logic signed [RW-1:0] SAT_MIN = RW'(OUT_MIN);

    // stage 2: weighted delta sum
    logic signed [SW-1:0]  sum;
    logic signed [SW-1:0]  dk;
    logic [COUNT_W-1:0]    idx;
    logic [3:0]            dadd;
    logic                  shift2;
    t_div_sel              sel;

    logic signed [SW-1:0]  r_sum2;
    logic [COORD_BITS-1:0] r_last2;
    logic [3:0]            r_dadd2;
    logic                  r_shift2;
    t_div_sel              r_sel2;

    always_comb begin
        sum = '0;
        dk  = '0;
        for (int k = 1; k < HIST_DEPTH; k++) begin
            dk = SW'($signed({1'b0, i_hist[k]}) - $signed({1'b0, i_hist[k-1]}));
            if (COUNT_W'(k) < i_count) begin
                sum = sum + SW'(k) * dk;
            end
        end
        idx = i_count - COUNT_W'(1);
        case (i_count)
            3'd3: begin
                dadd = 4'(TRI_3); shift2 = 1'b0; sel = DIV_BY3;
            end
            3'd4: begin
                dadd = 4'(TRI_4); shift2 = 1'b1; sel = DIV_BY3;
            end
            3'd5: begin
                dadd = 4'(TRI_5); shift2 = 1'b1; sel = DIV_BY5;
            end
            default: begin
                dadd = 4'd1; shift2 = 1'b0; sel = DIV_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_sum2   <= sum;
            r_last2  <= i_hist[idx];
            r_dadd2  <= dadd;
            r_shift2 <= shift2;
            r_sel2   <= sel;
        end
    end

    // stage 3: magnitude, rounding offset and power-of-two shift
    logic [SW-1:0] mag_full;
    logic [AW-1:0] mag;
    logic [MW-1:0] m;
    logic [MW-1:0] m_sh;

    logic [VW-1:0]         r_v3;
    logic                  r_neg3;
    logic [COORD_BITS-1:0] r_last3;
    t_div_sel              r_sel3;

    always_comb begin
        mag_full = r_sum2[SW-1] ? SW'(-r_sum2) : SW'(r_sum2);
        mag      = mag_full[AW-1:0];
        m        = {mag, 1'b0} + MW'(r_dadd2);
        m_sh     = r_shift2 ? (m >> 2) : (m >> 1);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_v3    <= m_sh[VW-1:0];
            r_neg3  <= r_sum2[SW-1];
            r_last3 <= r_last2;
            r_sel3  <= r_sel2;
        end
    end

    // stage 4: reciprocal multiply, quotient low by at most one
    logic [K-1:0]   recip;
    logic [2*K-1:0] prod;
    logic [VW-1:0]  q_est;

    logic [VW-1:0]         r_v4;
    logic [VW-1:0]         r_q4;
    logic                  r_neg4;
    logic [COORD_BITS-1:0] r_last4;
    t_div_sel              r_sel4;

    always_comb begin
        case (r_sel3)
            DIV_BY3: recip = R3;
            DIV_BY5: recip = R5;
            default: recip = '0;
        endcase
        prod  = (2*K)'(r_v3) * (2*K)'(recip);
        q_est = (r_sel3 == DIV_NONE) ? r_v3 : prod[2*K-1:K];
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s4) begin
            r_v4    <= r_v3;
            r_q4    <= q_est;
            r_neg4  <= r_neg3;
            r_last4 <= r_last3;
            r_sel4  <= r_sel3;
        end
    end

    // stage 5: quotient correction, sign, add last centre, clip
    logic [VW-1:0]        fact;
    logic [VW-1:0]        rem;
    logic [VW-1:0]        q;
    logic signed [RW-1:0] last_s;
    logic signed [RW-1:0] q_s;
    logic signed [RW-1:0] res;
    logic signed [RW-1:0] res_sat;

    logic [OUT_W-1:0] r_pred;

    always_comb begin
        case (r_sel4)
            DIV_BY3: fact = VW'(FACT_3);
            DIV_BY5: fact = VW'(FACT_5);
            default: fact = '0;
        endcase
        rem = r_v4 - VW'(r_q4 * fact);
        q   = r_q4;
        if (r_sel4 != DIV_NONE && rem >= fact) begin
            q = r_q4 + VW'(1);
        end
        last_s = $signed(RW'(r_last4));
        q_s    = $signed(RW'(q));
        res    = r_neg4 ? (last_s - q_s) : (last_s + q_s);
        if (res > SAT_MAX) begin
            res_sat = SAT_MAX;
        end else if (res < SAT_MIN) begin
            res_sat = SAT_MIN;
        end else begin
            res_sat = res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s5) begin
            r_pred <= res_sat[OUT_W-1:0];
        end
    end

    assign o_pred = r_pred;

endmodule

// ----- sv/track_next_position_predictor.sv -----
// Next-position predictor for one tracked object. Each input item carries a
// bounding box; its centre (edge plus half the size, truncated, clipped to
// 2^COORD_BITS-1) is pushed into a five-deep history, and the result item
// gives the predicted next centre: the newest centre plus the weighted mean
// of the last deltas (weights 1..4, divisors 1, 3, 6, 10), rounded half away
// from zero, clipped to the signed 14-bit range. tuser set starts a new
// track. The block takes one item per clock cycle unless output back-pressure
// stalls the stages; each item passes through the history update, weighted sum,
// rounding shift, reciprocal multiply and correction into the output register.
// That rate is set by the history register update, a read-modify-write of the
// centre history and its count. Every stage holds its own item, so input items
// keep flowing into empty stages while a result waits at the output.
module track_next_position_predictor
    import trk_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // box_left[11:0], box_top[23:12], box_width[36:24], box_height[49:37], zero
    input  logic [55:0] i_s_axis_tdata,
    // new_track[0]
    input  logic        i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // predicted_x[13:0], predicted_y[27:14], positions_held[30:28], zero[31]
    output logic [31:0] o_m_axis_tdata
);

    // input fields
    logic [11:0] box_left;
    logic [11:0] box_top;
    logic [12:0] box_width;
    logic [12:0] box_height;

    assign box_left   = i_s_axis_tdata[11:0];
    assign box_top    = i_s_axis_tdata[23:12];
    assign box_width  = i_s_axis_tdata[36:24];
    assign box_height = i_s_axis_tdata[49:37];

    // stage valids: history, weighted sum, shift, multiply, output
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic n_v1, n_v2, n_v3, n_v4, n_v5;
    t_pipe_en en;
    logic accept;

    // a stage loads when the one before holds an item and it is empty
    // or being emptied itself
    always_comb begin
        en.s5  = r_v4 && (!r_v5 || i_m_axis_tready);
        en.s4  = r_v3 && (!r_v4 || en.s5);
        en.s3  = r_v2 && (!r_v3 || en.s4);
        en.s2  = r_v1 && (!r_v2 || en.s3);
        o_s_axis_tready = !r_v1 || en.s2;
        accept = i_s_axis_tvalid && o_s_axis_tready;

        n_v1 = accept ? 1'b1 : (en.s2 ? 1'b0 : r_v1);
        n_v2 = en.s2  ? 1'b1 : (en.s3 ? 1'b0 : r_v2);
        n_v3 = en.s3  ? 1'b1 : (en.s4 ? 1'b0 : r_v3);
        n_v4 = en.s4  ? 1'b1 : (en.s5 ? 1'b0 : r_v4);
        n_v5 = en.s5  ? 1'b1 : (i_m_axis_tready ? 1'b0 : r_v5);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
            r_v2 <= n_v2;
            r_v3 <= n_v3;
            r_v4 <= n_v4;
            r_v5 <= n_v5;
        end
    end

    // box centres
    logic [COORD_BITS-1:0] cx;
    logic [COORD_BITS-1:0] cy;

    trk_center #(.COORD_BITS(COORD_BITS)) u_center_x (
        .i_edge   (box_left),
        .i_size   (box_width),
        .o_center (cx)
    );

    trk_center #(.COORD_BITS(COORD_BITS)) u_center_y (
        .i_edge   (box_top),
        .i_size   (box_height),
        .o_center (cy)
    );

    // centre history, updated as each item is accepted; it stays put
    // until the weighted-sum stage has taken it
    logic [COORD_BITS-1:0] hx [HIST_DEPTH];
    logic [COORD_BITS-1:0] hy [HIST_DEPTH];
    logic [COUNT_W-1:0]    count;

    trk_history #(.COORD_BITS(COORD_BITS)) u_history (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (accept),
        .i_new_track (i_s_axis_tuser),
        .i_cx        (cx),
        .i_cy        (cy),
        .o_hx        (hx),
        .o_hy        (hy),
        .o_count     (count)
    );

    // prediction lanes, one per axis
    logic [OUT_W-1:0] pred_x;
    logic [OUT_W-1:0] pred_y;

    trk_lane #(.COORD_BITS(COORD_BITS)) u_lane_x (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_hist  (hx),
        .i_count (count),
        .o_pred  (pred_x)
    );

    trk_lane #(.COORD_BITS(COORD_BITS)) u_lane_y (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_hist  (hy),
        .i_count (count),
        .o_pred  (pred_y)
    );

    // positions held travels alongside the lanes
    logic [COUNT_W-1:0] r_cnt2, r_cnt3, r_cnt4, r_cnt5;

    always_ff @(posedge i_clk) begin
        if (en.s2) begin
            r_cnt2 <= count;
        end
        if (en.s3) begin
            r_cnt3 <= r_cnt2;
        end
        if (en.s4) begin
            r_cnt4 <= r_cnt3;
        end
        if (en.s5) begin
            r_cnt5 <= r_cnt4;
        end
    end

    assign o_m_axis_tvalid = r_v5;
    assign o_m_axis_tdata  = {1'b0, r_cnt5, pred_y, pred_x};

endmodule

// ----- tb/track_next_position_predictor_test.sv -----
`timescale 1ns / 100ps

module track_next_position_predictor_test
    import trk_pkg::*;
();

    localparam int COORD_BITS  = 12;
    localparam int COORD_MAX   = (1 << COORD_BITS) - 1;
    localparam int TOTAL_BOXES = 1050;
    localparam int DIR_ROWS    = 21;

    // one bounding box as it travels on the slave side
    typedef struct packed {
        logic        new_track;
        logic [11:0] left;
        logic [11:0] top;
        logic [12:0] width;
        logic [12:0] height;
    } t_box;

    // one predicted next centre as it leaves on the master side
    typedef struct packed {
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
        logic [COUNT_W-1:0]      held;
    } t_prediction;

    // directed row: the box, and a hand-typed prediction where typed is set
    typedef struct packed {
        t_box        box;
        logic        typed;
        t_prediction want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    // box_left[11:0], box_top[23:12], box_width[36:24], box_height[49:37], zero
    logic [55:0] i_s_axis_tdata = '0;
    // new_track[0]
    logic        i_s_axis_tuser = 1'b0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    // predicted_x[13:0], predicted_y[27:14], positions_held[30:28], zero[31]
    logic [31:0] o_m_axis_tdata;

    // predictor state: centre history, oldest entry first
    int centre_x [HIST_DEPTH];
    int centre_y [HIST_DEPTH];
    int centres_held = 0;

    t_prediction expected_predictions [$];

    bit quiet = 1'b0;
    int boxes_sent = 0;
    int tracks_started = 0;
    int results_checked = 0;
    int full_history_results = 0;
    int mismatches = 0;

    // extremes, zero sizes, saturation, full history and rounding on the halves
    t_row dir_table [DIR_ROWS] = '{
        // first box after reset without a new track
        '{'{1'b0, 12'd100, 12'd200, 13'd50, 13'd31}, 1'b1, '{14'sd125, 14'sd215, 3'd1}},
        // centre past the coordinate maximum saturates
        '{'{1'b1, 12'd4095, 12'd4095, 13'd8191, 13'd8191}, 1'b1,
          '{14'sd4095, 14'sd4095, 3'd1}},
        // zero width and height give the edges themselves
        '{'{1'b1, 12'd0, 12'd0, 13'd0, 13'd0}, 1'b1, '{14'sd0, 14'sd0, 3'd1}},
        // largest single delta
        '{'{1'b0, 12'd4095, 12'd0, 13'd8191, 13'd0}, 1'b1, '{14'sd8190, 14'sd0, 3'd2}},
        '{'{1'b0, 12'd0, 12'd4095, 13'd0, 13'd8191}, 1'b0, '0},
        '{'{1'b0, 12'd4095, 12'd0, 13'd4096, 13'd1}, 1'b0, '0},
        '{'{1'b0, 12'd0, 12'd4095, 13'd1, 13'd4096}, 1'b0, '0},
        // history full from here on, oldest centre dropped
        '{'{1'b0, 12'd4095, 12'd4095, 13'd8191, 13'd8191}, 1'b0, '0},
        '{'{1'b0, 12'd0, 12'd0, 13'd0, 13'd0}, 1'b0, '0},
        // four centres, weighted sum of plus and minus three rounds away from zero
        '{'{1'b1, 12'd10, 12'd10, 13'd0, 13'd0}, 1'b1, '{14'sd10, 14'sd10, 3'd1}},
        '{'{1'b0, 12'd10, 12'd10, 13'd0, 13'd0}, 1'b1, '{14'sd10, 14'sd10, 3'd2}},
        '{'{1'b0, 12'd10, 12'd10, 13'd0, 13'd0}, 1'b0, '0},
        '{'{1'b0, 12'd11, 12'd9, 13'd0, 13'd0}, 1'b0, '0},
        // five centres, weighted sum of plus and minus five rounds away from zero
        '{'{1'b1, 12'd20, 12'd20, 13'd0, 13'd0}, 1'b1, '{14'sd20, 14'sd20, 3'd1}},
        '{'{1'b0, 12'd21, 12'd19, 13'd0, 13'd0}, 1'b0, '0},
        '{'{1'b0, 12'd21, 12'd19, 13'd0, 13'd0}, 1'b0, '0},
        '{'{1'b0, 12'd21, 12'd19, 13'd0, 13'd0}, 1'b0, '0},
        '{'{1'b0, 12'd22, 12'd18, 13'd0, 13'd0}, 1'b0, '0},
        // centre just at the maximum without saturating
        '{'{1'b0, 12'd2048, 12'd2048, 13'd4095, 13'd4095}, 1'b0, '0},
        '{'{1'b1, 12'd0, 12'd4095, 13'd4096, 13'd0}, 1'b0, '0},
        '{'{1'b0, 12'd4095, 12'd0, 13'd1, 13'd8191}, 1'b0, '0}
    };

    track_next_position_predictor #(
        .COORD_BITS(COORD_BITS)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // newest centre plus the weighted mean of the deltas, halves away from zero
    function automatic int weighted_next(input bit axis_y);
        int h [HIST_DEPTH];
        int sum;
        int divisor;
        int mag;
        int q;
        for (int k = 0; k < HIST_DEPTH; k++) h[k] = axis_y ? centre_y[k] : centre_x[k];
        sum = 0;
        divisor = 1;
        if (centres_held >= 2) begin
            for (int k = 1; k < centres_held; k++) sum += k * (h[k] - h[k-1]);
            divisor = (centres_held - 1) * centres_held / 2;
        end
        mag = (sum < 0) ? -sum : sum;
        q = (2 * mag + divisor) / (2 * divisor);
        return h[centres_held-1] + ((sum < 0) ? -q : q);
    endfunction

    function automatic logic signed [OUT_W-1:0] clip_to_port(input int v);
        int c;
        c = (v < OUT_MIN) ? OUT_MIN : (v > OUT_MAX) ? OUT_MAX : v;
        return c[OUT_W-1:0];
    endfunction

    // push the box centre into the history and work out the next centre
    function automatic t_prediction advance_track(input t_box b);
        int cx;
        int cy;
        t_prediction p;
        cx = b.left + (b.width >> 1);
        cy = b.top + (b.height >> 1);
        if (cx > COORD_MAX) cx = COORD_MAX;
        if (cy > COORD_MAX) cy = COORD_MAX;
        if (b.new_track) centres_held = 0;
        if (centres_held == HIST_DEPTH) begin
            for (int k = 1; k < HIST_DEPTH; k++) begin
                centre_x[k-1] = centre_x[k];
                centre_y[k-1] = centre_y[k];
            end
            centres_held = HIST_DEPTH - 1;
        end
        centre_x[centres_held] = cx;
        centre_y[centres_held] = cy;
        centres_held++;
        p.x = clip_to_port(weighted_next(1'b0));
        p.y = clip_to_port(weighted_next(1'b1));
        p.held = centres_held[COUNT_W-1:0];
        return p;
    endfunction

    // append one expected prediction at the tail of the queue
    function automatic void queue_prediction(input t_prediction p);
        expected_predictions.insert(expected_predictions.size(), p);
    endfunction

    // offer one box, wait for it to be taken, then record its prediction
    task automatic send_box(input t_box b, input logic typed, input t_prediction typed_want);
        t_prediction p;
        while (!quiet && $urandom_range(99) < 8) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {6'b0, b.height, b.width, b.top, b.left};
        i_s_axis_tuser  <= b.new_track;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        p = advance_track(b);
        queue_prediction(typed ? typed_want : p);
        boxes_sent++;
        if (b.new_track) tracks_started++;
    endtask

    // hold the sender until every outstanding prediction has come back
    task automatic drain_predictions;
        i_s_axis_tvalid <= 1'b0;
        while (expected_predictions.size() != 0) @(posedge i_clk);
    endtask

    // result side: random back-pressure and field-by-field comparison
    always @(posedge i_clk) begin : result_check
        t_prediction got;
        t_prediction want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.x    = o_m_axis_tdata[13:0];
            got.y    = o_m_axis_tdata[27:14];
            got.held = o_m_axis_tdata[30:28];
            if (expected_predictions.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %h", $time, o_m_axis_tdata);
                mismatches++;
            end else begin
                want = expected_predictions.pop_front();
                if (got.x !== want.x) begin
                    $display("%0t: predicted_x expected %0d got %0d", $time, want.x, got.x);
                    mismatches++;
                end
                if (got.y !== want.y) begin
                    $display("%0t: predicted_y expected %0d got %0d", $time, want.y, got.y);
                    mismatches++;
                end
                if (got.held !== want.held) begin
                    $display("%0t: positions_held expected %0d got %0d", $time, want.held,
                             got.held);
                    mismatches++;
                end
                results_checked++;
                if (want.held == HIST_DEPTH) full_history_results++;
            end
        end
        i_m_axis_tready <= quiet || ($urandom_range(99) >= 8);
    end

    initial begin : stimulus
        t_box b;
        int   px;
        int   py;
        int   vx;
        int   vy;
        int   w;
        int   h;
        int   track_len;
        bit   drained_mid;
        drained_mid = 1'b0;
        for (int k = 0; k < HIST_DEPTH; k++) begin
            centre_x[k] = 0;
            centre_y[k] = 0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++)
            send_box(dir_table[r].box, dir_table[r].typed, dir_table[r].want);
        drain_predictions();

        while (boxes_sent < TOTAL_BOXES) begin
            // a stretch with no idling on either side
            quiet = (boxes_sent >= 400 && boxes_sent < 600);
            if (!drained_mid && boxes_sent >= 700) begin
                drain_predictions();
                drained_mid = 1'b1;
            end
            if ($urandom_range(9) == 0) begin
                // noise: every field at random over its full width
                b.new_track = 1'($urandom_range(1));
                b.left      = 12'($urandom_range(4095));
                b.top       = 12'($urandom_range(4095));
                b.width     = 13'($urandom_range(8191));
                b.height    = 13'($urandom_range(8191));
                send_box(b, 1'b0, '0);
            end else begin
                // a moving object; now and then a track that never got its start flag
                track_len = $urandom_range(1, 14);
                px = $urandom_range(4095);
                py = $urandom_range(4095);
                vx = $urandom_range(160) - 80;
                vy = $urandom_range(160) - 80;
                w  = ($urandom_range(9) == 0) ? $urandom_range(8191) : $urandom_range(1, 4096);
                h  = ($urandom_range(9) == 0) ? $urandom_range(8191) : $urandom_range(1, 4096);
                for (int i = 0; i < track_len; i++) begin
                    b.new_track = (i == 0) && ($urandom_range(9) != 0);
                    b.left   = 12'((px < 0) ? 0 : (px > 4095) ? 4095 : px);
                    b.top    = 12'((py < 0) ? 0 : (py > 4095) ? 4095 : py);
                    b.width  = 13'(w);
                    b.height = 13'(h);
                    send_box(b, 1'b0, '0);
                    px += vx + $urandom_range(8) - 4;
                    py += vy + $urandom_range(8) - 4;
                    w  = ($urandom_range(3) == 0) ? $urandom_range(1, 4096) : w;
                end
            end
        end
        drain_predictions();
        quiet = 1'b0;
        // let any stray result turn up before judging
        repeat (10) @(posedge i_clk);

        $display("covered %0d boxes in %0d started tracks, %0d results checked",
                 boxes_sent, tracks_started, results_checked);
        $display("%0d results came from a full five-centre history", full_history_results);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin : watchdog
        #3_000_000;
        $display("timeout with %0d predictions outstanding", expected_predictions.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- files.f -----
sv/trk_pkg.sv
sv/trk_center.sv
sv/trk_history.sv
sv/trk_lane.sv
sv/track_next_position_predictor.sv
tb/track_next_position_predictor_test.sv
